/* sv/cis2d_pkg.sv */
// ----------------------------------------------------------------------------
// cis2d_pkg: shared types, constants and microprogram
// Fixed-point helpers, the operation and operand codes of the solver datapath,
// and the step table that the controller walks through for each word.
// ----------------------------------------------------------------------------
package cis2d_pkg;

	localparam int FRAC_BITS = 16;
	localparam int Q14       = 14;
	localparam int DIV_W     = 2 * FRAC_BITS + 1;
	localparam int CNT_W     = $clog2(DIV_W + 1);
	localparam int STEP_W    = 8;

	typedef logic signed [31:0] q_t;
	typedef logic [DIV_W-1:0]   quo_t;
	typedef logic [STEP_W-1:0]  step_t;

	// Register indexes of the configuration port.
	localparam logic [3:0] CFG_ARM_A    = 4'd0;
	localparam logic [3:0] CFG_ARM_B    = 4'd1;
	localparam logic [3:0] CFG_NORMAL   = 4'd2;
	localparam logic [3:0] CFG_TANGENT  = 4'd3;
	localparam logic [3:0] CFG_DEPTH    = 4'd4;
	localparam logic [3:0] CFG_INV_MASS = 4'd5;
	localparam logic [3:0] CFG_INV_INER = 4'd6;
	localparam logic [3:0] CFG_COEF     = 4'd7;

	typedef enum logic [2:0] {
		OP_MUL, OP_MULQ, OP_ADD, OP_SUB, OP_NEG, OP_MIN, OP_MAX, OP_RECIP
	} op_t;

	typedef enum logic [5:0] {
		S_ZERO, S_RAX, S_RAY, S_RBX, S_RBY, S_NX, S_NY, S_TX, S_TY, S_DEP,
		S_MA, S_MB, S_IA, S_IB, S_CR, S_CF, S_BDT,
		S_V0, S_V1, S_V2, S_V3, S_V4, S_V5,
		S_NT, S_FT, S_MN, S_MT,
		S_O0, S_O1, S_O2, S_O3, S_O4, S_O5,
		S_T0, S_T1, S_T2, S_T3,
		S_JAN, S_JBN, S_JAT, S_JBT
	} src_t;

	localparam int NUM_SRC = 41;

	typedef enum logic [4:0] {
		D_NT, D_FT, D_MN, D_MT,
		D_O0, D_O1, D_O2, D_O3, D_O4, D_O5,
		D_T0, D_T1, D_T2, D_T3,
		D_JAN, D_JBN, D_JAT, D_JBT
	} dst_t;

	typedef struct packed {
		op_t  op;
		src_t a;
		src_t b;
		dst_t d;
	} uop_t;

	typedef struct packed {
		logic  load;
		logic  exec;
		logic  div_start;
		logic  publish;
		step_t step;
	} cmd_t;

	typedef struct packed {
		logic restart;
		logic div_done;
	} sts_t;

	// Last step of the shared prelude, first and last steps of the item.
	localparam step_t STEP_SPLIT  = 8'd13;
	localparam step_t STEP_NORMAL = 8'd32;
	localparam step_t STEP_LAST   = 8'd132;

	function automatic q_t sat64(input logic signed [63:0] v);
		if (v > 64'sd2147483647)       return 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648) return 32'sh8000_0000;
		else                           return v[31:0];
	endfunction

	function automatic q_t sat33(input logic signed [32:0] v);
		if (v[32] != v[31]) return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else                return v[31:0];
	endfunction

	function automatic uop_t mk(input op_t op, input src_t a, input src_t b, input dst_t d);
		uop_t u;
		u.op = op;
		u.a  = a;
		u.b  = b;
		u.d  = d;
		return u;
	endfunction

	// One entry per step. Steps 14 to 31 run only on a restart word.
	function automatic uop_t uop_rom(input step_t s);
		uop_t u;
		case (s)
			// Angular Jacobian terms for the normal and the tangent.
			8'd0:   u = mk(OP_MUL, S_RAX, S_NY, D_T0);
			8'd1:   u = mk(OP_MUL, S_RAY, S_NX, D_T1);
			8'd2:   u = mk(OP_SUB, S_T0, S_T1, D_T0);
			8'd3:   u = mk(OP_NEG, S_T0, S_ZERO, D_JAN);
			8'd4:   u = mk(OP_MUL, S_RBX, S_NY, D_T0);
			8'd5:   u = mk(OP_MUL, S_RBY, S_NX, D_T1);
			8'd6:   u = mk(OP_SUB, S_T0, S_T1, D_JBN);
			8'd7:   u = mk(OP_MUL, S_RAX, S_TY, D_T0);
			8'd8:   u = mk(OP_MUL, S_RAY, S_TX, D_T1);
			8'd9:   u = mk(OP_SUB, S_T0, S_T1, D_T0);
			8'd10:  u = mk(OP_NEG, S_T0, S_ZERO, D_JAT);
			8'd11:  u = mk(OP_MUL, S_RBX, S_TY, D_T0);
			8'd12:  u = mk(OP_MUL, S_RBY, S_TX, D_T1);
			8'd13:  u = mk(OP_SUB, S_T0, S_T1, D_JBT);
			// Restart: clear totals, recompute both effective masses.
			8'd14:  u = mk(OP_ADD, S_ZERO, S_ZERO, D_NT);
			8'd15:  u = mk(OP_ADD, S_ZERO, S_ZERO, D_FT);
			8'd16:  u = mk(OP_MUL, S_IA, S_JAN, D_T0);
			8'd17:  u = mk(OP_MUL, S_T0, S_JAN, D_T0);
			8'd18:  u = mk(OP_ADD, S_MA, S_T0, D_T0);
			8'd19:  u = mk(OP_ADD, S_T0, S_MB, D_T0);
			8'd20:  u = mk(OP_MUL, S_IB, S_JBN, D_T1);
			8'd21:  u = mk(OP_MUL, S_T1, S_JBN, D_T1);
			8'd22:  u = mk(OP_ADD, S_T0, S_T1, D_T0);
			8'd23:  u = mk(OP_RECIP, S_T0, S_ZERO, D_MN);
			8'd24:  u = mk(OP_MUL, S_IA, S_JAT, D_T0);
			8'd25:  u = mk(OP_MUL, S_T0, S_JAT, D_T0);
			8'd26:  u = mk(OP_ADD, S_MA, S_T0, D_T0);
			8'd27:  u = mk(OP_ADD, S_T0, S_MB, D_T0);
			8'd28:  u = mk(OP_MUL, S_IB, S_JBT, D_T1);
			8'd29:  u = mk(OP_MUL, S_T1, S_JBT, D_T1);
			8'd30:  u = mk(OP_ADD, S_T0, S_T1, D_T0);
			8'd31:  u = mk(OP_RECIP, S_T0, S_ZERO, D_MT);
			// Normal pass: Jacobian times velocity.
			8'd32:  u = mk(OP_MUL, S_NX, S_V0, D_T0);
			8'd33:  u = mk(OP_MUL, S_NY, S_V1, D_T1);
			8'd34:  u = mk(OP_ADD, S_T0, S_T1, D_T0);
			8'd35:  u = mk(OP_NEG, S_T0, S_ZERO, D_T0);
			8'd36:  u = mk(OP_MUL, S_JAN, S_V2, D_T1);
			8'd37:  u = mk(OP_ADD, S_T0, S_T1, D_T0);
			8'd38:  u = mk(OP_MUL, S_NX, S_V3, D_T1);
			8'd39:  u = mk(OP_MUL, S_NY, S_V4, D_T2);
			8'd40:  u = mk(OP_ADD, S_T1, S_T2, D_T1);
			8'd41:  u = mk(OP_ADD, S_T0, S_T1, D_T0);
			8'd42:  u = mk(OP_MUL, S_JBN, S_V5, D_T1);
			8'd43:  u = mk(OP_ADD, S_T0, S_T1, D_T0);
			// Relative velocity x and y.
			8'd44:  u = mk(OP_NEG, S_V0, S_ZERO, D_T1);
			8'd45:  u = mk(OP_MUL, S_V2, S_RAY, D_T2);
			8'd46:  u = mk(OP_ADD, S_T1, S_T2, D_T1);
			8'd47:  u = mk(OP_ADD, S_T1, S_V3, D_T1);
			8'd48:  u = mk(OP_MUL, S_V5, S_RBY, D_T2);
			8'd49:  u = mk(OP_NEG, S_T2, S_ZERO, D_T2);
			8'd50:  u = mk(OP_ADD, S_T1, S_T2, D_T1);
			8'd51:  u = mk(OP_NEG, S_V1, S_ZERO, D_T2);
			8'd52:  u = mk(OP_MUL, S_V2, S_RAX, D_T3);
			8'd53:  u = mk(OP_NEG, S_T3, S_ZERO, D_T3);
			8'd54:  u = mk(OP_ADD, S_T2, S_T3, D_T2);
			8'd55:  u = mk(OP_ADD, S_T2, S_V4, D_T2);
			8'd56:  u = mk(OP_MUL, S_V5, S_RBX, D_T3);
			8'd57:  u = mk(OP_ADD, S_T2, S_T3, D_T2);
			// Restitution and depth bias.
			8'd58:  u = mk(OP_MUL, S_NX, S_T1, D_T1);
			8'd59:  u = mk(OP_MUL, S_NY, S_T2, D_T2);
			8'd60:  u = mk(OP_ADD, S_T1, S_T2, D_T1);
			8'd61:  u = mk(OP_MULQ, S_CR, S_T1, D_T1);
			8'd62:  u = mk(OP_MUL, S_BDT, S_DEP, D_T2);
			8'd63:  u = mk(OP_NEG, S_T2, S_ZERO, D_T2);
			8'd64:  u = mk(OP_ADD, S_T2, S_T1, D_T1);
			// Normal impulse and its clamped total.
			8'd65:  u = mk(OP_ADD, S_T0, S_T1, D_T0);
			8'd66:  u = mk(OP_NEG, S_T0, S_ZERO, D_T0);
			8'd67:  u = mk(OP_MUL, S_MN, S_T0, D_T0);
			8'd68:  u = mk(OP_ADD, S_NT, S_T0, D_T1);
			8'd69:  u = mk(OP_MAX, S_T1, S_ZERO, D_T1);
			8'd70:  u = mk(OP_SUB, S_T1, S_NT, D_T0);
			8'd71:  u = mk(OP_ADD, S_T1, S_ZERO, D_NT);
			// Apply the normal impulse change.
			8'd72:  u = mk(OP_NEG, S_NX, S_ZERO, D_T1);
			8'd73:  u = mk(OP_MUL, S_MA, S_T1, D_T1);
			8'd74:  u = mk(OP_MUL, S_T1, S_T0, D_T1);
			8'd75:  u = mk(OP_ADD, S_V0, S_T1, D_O0);
			8'd76:  u = mk(OP_NEG, S_NY, S_ZERO, D_T1);
			8'd77:  u = mk(OP_MUL, S_MA, S_T1, D_T1);
			8'd78:  u = mk(OP_MUL, S_T1, S_T0, D_T1);
			8'd79:  u = mk(OP_ADD, S_V1, S_T1, D_O1);
			8'd80:  u = mk(OP_MUL, S_IA, S_JAN, D_T1);
			8'd81:  u = mk(OP_MUL, S_T1, S_T0, D_T1);
			8'd82:  u = mk(OP_ADD, S_V2, S_T1, D_O2);
			8'd83:  u = mk(OP_MUL, S_MB, S_NX, D_T1);
			8'd84:  u = mk(OP_MUL, S_T1, S_T0, D_T1);
			8'd85:  u = mk(OP_ADD, S_V3, S_T1, D_O3);
			8'd86:  u = mk(OP_MUL, S_MB, S_NY, D_T1);
			8'd87:  u = mk(OP_MUL, S_T1, S_T0, D_T1);
			8'd88:  u = mk(OP_ADD, S_V4, S_T1, D_O4);
			8'd89:  u = mk(OP_MUL, S_IB, S_JBN, D_T1);
			8'd90:  u = mk(OP_MUL, S_T1, S_T0, D_T1);
			8'd91:  u = mk(OP_ADD, S_V5, S_T1, D_O5);
			// Friction pass on the incoming velocities.
			8'd92:  u = mk(OP_MUL, S_TX, S_V0, D_T0);
			8'd93:  u = mk(OP_MUL, S_TY, S_V1, D_T1);
			8'd94:  u = mk(OP_ADD, S_T0, S_T1, D_T0);
			8'd95:  u = mk(OP_NEG, S_T0, S_ZERO, D_T0);
			8'd96:  u = mk(OP_MUL, S_JAT, S_V2, D_T1);
			8'd97:  u = mk(OP_ADD, S_T0, S_T1, D_T0);
			8'd98:  u = mk(OP_MUL, S_TX, S_V3, D_T1);
			8'd99:  u = mk(OP_MUL, S_TY, S_V4, D_T2);
			8'd100: u = mk(OP_ADD, S_T1, S_T2, D_T1);
			8'd101: u = mk(OP_ADD, S_T0, S_T1, D_T0);
			8'd102: u = mk(OP_MUL, S_JBT, S_V5, D_T1);
			8'd103: u = mk(OP_ADD, S_T0, S_T1, D_T0);
			8'd104: u = mk(OP_NEG, S_T0, S_ZERO, D_T0);
			8'd105: u = mk(OP_MUL, S_MT, S_T0, D_T0);
			8'd106: u = mk(OP_MULQ, S_CF, S_NT, D_T1);
			8'd107: u = mk(OP_NEG, S_T1, S_ZERO, D_T2);
			8'd108: u = mk(OP_ADD, S_FT, S_T0, D_T3);
			8'd109: u = mk(OP_MIN, S_T3, S_T1, D_T3);
			8'd110: u = mk(OP_MAX, S_T3, S_T2, D_T3);
			8'd111: u = mk(OP_SUB, S_T3, S_FT, D_T0);
			8'd112: u = mk(OP_ADD, S_T3, S_ZERO, D_FT);
			// Apply the friction impulse change.
			8'd113: u = mk(OP_NEG, S_TX, S_ZERO, D_T1);
			8'd114: u = mk(OP_MUL, S_MA, S_T1, D_T1);
			8'd115: u = mk(OP_MUL, S_T1, S_T0, D_T1);
			8'd116: u = mk(OP_ADD, S_O0, S_T1, D_O0);
			8'd117: u = mk(OP_NEG, S_TY, S_ZERO, D_T1);
			8'd118: u = mk(OP_MUL, S_MA, S_T1, D_T1);
			8'd119: u = mk(OP_MUL, S_T1, S_T0, D_T1);
			8'd120: u = mk(OP_ADD, S_O1, S_T1, D_O1);
			8'd121: u = mk(OP_MUL, S_IA, S_JAT, D_T1);
			8'd122: u = mk(OP_MUL, S_T1, S_T0, D_T1);
			8'd123: u = mk(OP_ADD, S_O2, S_T1, D_O2);
			8'd124: u = mk(OP_MUL, S_MB, S_TX, D_T1);
			8'd125: u = mk(OP_MUL, S_T1, S_T0, D_T1);
			8'd126: u = mk(OP_ADD, S_O3, S_T1, D_O3);
			8'd127: u = mk(OP_MUL, S_MB, S_TY, D_T1);
			8'd128: u = mk(OP_MUL, S_T1, S_T0, D_T1);
			8'd129: u = mk(OP_ADD, S_O4, S_T1, D_O4);
			8'd130: u = mk(OP_MUL, S_IB, S_JBT, D_T1);
			8'd131: u = mk(OP_MUL, S_T1, S_T0, D_T1);
			8'd132: u = mk(OP_ADD, S_O5, S_T1, D_O5);
			default: u = mk(OP_ADD, S_ZERO, S_ZERO, D_T3);
		endcase
		return u;
	endfunction

endpackage

/* sv/cis2d_if.sv */
// ----------------------------------------------------------------------------
// cis2d_if: word channels of the contact solver
// Input channel with both bodies' velocities, output channel with results.
// ----------------------------------------------------------------------------
interface cis2d_in_if;
	logic        valid;
	logic        ready;
	logic        restart;
	logic [31:0] vel_a_x;
	logic [31:0] vel_a_y;
	logic [31:0] spin_a;
	logic [31:0] vel_b_x;
	logic [31:0] vel_b_y;
	logic [31:0] spin_b;

	modport source (output valid, restart, vel_a_x, vel_a_y, spin_a, vel_b_x, vel_b_y,
		spin_b, input ready);
	modport sink (input valid, restart, vel_a_x, vel_a_y, spin_a, vel_b_x, vel_b_y,
		spin_b, output ready);
endinterface

interface cis2d_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] new_vel_a_x;
	logic [31:0] new_vel_a_y;
	logic [31:0] new_spin_a;
	logic [31:0] new_vel_b_x;
	logic [31:0] new_vel_b_y;
	logic [31:0] new_spin_b;
	logic [30:0] normal_impulse_total;
	logic [31:0] friction_impulse_total;

	modport source (output valid, new_vel_a_x, new_vel_a_y, new_spin_a, new_vel_b_x,
		new_vel_b_y, new_spin_b, normal_impulse_total, friction_impulse_total,
		input ready);
	modport sink (input valid, new_vel_a_x, new_vel_a_y, new_spin_a, new_vel_b_x,
		new_vel_b_y, new_spin_b, normal_impulse_total, friction_impulse_total,
		output ready);
endinterface

/* sv/cis2d_recip.sv */
// ----------------------------------------------------------------------------
// cis2d_recip: fixed-point reciprocal
// Restoring division of 2^(2*FRAC_BITS) by a signed word, one quotient bit per
// cycle, truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module cis2d_recip (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  cis2d_pkg::q_t   den,
	output logic            done,
	output cis2d_pkg::q_t   quo
);

	logic                        busy_q;
	logic                        done_q;
	logic                        neg_q;
	logic                        zero_q;
	logic [cis2d_pkg::CNT_W-1:0] cnt_q;
	logic [33:0]                 rem_q;
	logic [31:0]                 mag_q;
	cis2d_pkg::quo_t             num_q;
	cis2d_pkg::quo_t             quo_q;
	logic [33:0]                 rem_sh;
	logic                        fits;

	assign rem_sh = {rem_q[32:0], num_q[cis2d_pkg::DIV_W-1]};
	assign fits   = rem_sh >= {2'b00, mag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			zero_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			mag_q  <= '0;
			num_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				neg_q  <= den[31];
				zero_q <= (den == '0);
				mag_q  <= den[31] ? 32'(-den) : 32'(den);
				rem_q  <= '0;
				quo_q  <= '0;
				num_q  <= cis2d_pkg::quo_t'(1) << (cis2d_pkg::DIV_W - 1);
				cnt_q  <= cis2d_pkg::CNT_W'(cis2d_pkg::DIV_W);
			end else if (busy_q) begin
				rem_q <= fits ? rem_sh - {2'b00, mag_q} : rem_sh;
				quo_q <= {quo_q[cis2d_pkg::DIV_W-2:0], fits};
				num_q <= num_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == cis2d_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (zero_q) begin
			quo = '0;
		end else if (!neg_q) begin
			quo = (quo_q > cis2d_pkg::quo_t'(64'd2147483647)) ? 32'sh7FFF_FFFF
				: cis2d_pkg::q_t'(quo_q[31:0]);
		end else begin
			quo = (quo_q > cis2d_pkg::quo_t'(64'd2147483648)) ? 32'sh8000_0000
				: cis2d_pkg::q_t'(-quo_q[31:0]);
		end
	end

	assign done = done_q;

endmodule

/* sv/cis2d_dp.sv */
// ----------------------------------------------------------------------------
// cis2d_dp: solver datapath
// Configuration registers, working registers, one multiplier with saturating
// add and compare, the reciprocal unit and the output word register.
// ----------------------------------------------------------------------------
module cis2d_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [3:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	input  logic              restart,
	input  logic [31:0]       vel_a_x,
	input  logic [31:0]       vel_a_y,
	input  logic [31:0]       spin_a,
	input  logic [31:0]       vel_b_x,
	input  logic [31:0]       vel_b_y,
	input  logic [31:0]       spin_b,
	input  cis2d_pkg::cmd_t   cmd,
	output cis2d_pkg::sts_t   sts,
	output logic [31:0]       new_vel_a_x,
	output logic [31:0]       new_vel_a_y,
	output logic [31:0]       new_spin_a,
	output logic [31:0]       new_vel_b_x,
	output logic [31:0]       new_vel_b_y,
	output logic [31:0]       new_spin_b,
	output logic [30:0]       normal_impulse_total,
	output logic [31:0]       friction_impulse_total
);

	logic [63:0] arm_a_q, arm_b_q, normal_q, tangent_q, inv_mass_q, inv_iner_q, coef_q;
	logic [31:0] depth_q;
	logic        restart_q;
	cis2d_pkg::q_t v_q   [6];
	cis2d_pkg::q_t o_q   [6];
	cis2d_pkg::q_t t_q   [4];
	cis2d_pkg::q_t nt_q, ft_q, mn_q, mt_q, jan_q, jbn_q, jat_q, jbt_q;
	cis2d_pkg::q_t src_val [cis2d_pkg::NUM_SRC];
	cis2d_pkg::uop_t       u;
	cis2d_pkg::q_t         opa, opb, res, wdata, div_quo;
	logic signed [63:0]    prod, prod_sh;
	logic                  div_done;
	logic                  wen;
	logic [31:0] out_q [6];
	logic [30:0] out_nt_q;
	logic [31:0] out_ft_q;

	assign u = cis2d_pkg::uop_rom(cmd.step);

	always_comb begin
		src_val[cis2d_pkg::S_ZERO] = '0;
		src_val[cis2d_pkg::S_RAX]  = arm_a_q[63:32];
		src_val[cis2d_pkg::S_RAY]  = arm_a_q[31:0];
		src_val[cis2d_pkg::S_RBX]  = arm_b_q[63:32];
		src_val[cis2d_pkg::S_RBY]  = arm_b_q[31:0];
		src_val[cis2d_pkg::S_NX]   = normal_q[63:32];
		src_val[cis2d_pkg::S_NY]   = normal_q[31:0];
		src_val[cis2d_pkg::S_TX]   = tangent_q[63:32];
		src_val[cis2d_pkg::S_TY]   = tangent_q[31:0];
		src_val[cis2d_pkg::S_DEP]  = depth_q;
		src_val[cis2d_pkg::S_MA]   = inv_mass_q[63:32];
		src_val[cis2d_pkg::S_MB]   = inv_mass_q[31:0];
		src_val[cis2d_pkg::S_IA]   = inv_iner_q[63:32];
		src_val[cis2d_pkg::S_IB]   = inv_iner_q[31:0];
		src_val[cis2d_pkg::S_CR]   = {16'h0000, coef_q[63:48]};
		src_val[cis2d_pkg::S_CF]   = {16'h0000, coef_q[47:32]};
		src_val[cis2d_pkg::S_BDT]  = coef_q[31:0];
		src_val[cis2d_pkg::S_V0]   = v_q[0];
		src_val[cis2d_pkg::S_V1]   = v_q[1];
		src_val[cis2d_pkg::S_V2]   = v_q[2];
		src_val[cis2d_pkg::S_V3]   = v_q[3];
		src_val[cis2d_pkg::S_V4]   = v_q[4];
		src_val[cis2d_pkg::S_V5]   = v_q[5];
		src_val[cis2d_pkg::S_NT]   = nt_q;
		src_val[cis2d_pkg::S_FT]   = ft_q;
		src_val[cis2d_pkg::S_MN]   = mn_q;
		src_val[cis2d_pkg::S_MT]   = mt_q;
		src_val[cis2d_pkg::S_O0]   = o_q[0];
		src_val[cis2d_pkg::S_O1]   = o_q[1];
		src_val[cis2d_pkg::S_O2]   = o_q[2];
		src_val[cis2d_pkg::S_O3]   = o_q[3];
		src_val[cis2d_pkg::S_O4]   = o_q[4];
		src_val[cis2d_pkg::S_O5]   = o_q[5];
		src_val[cis2d_pkg::S_T0]   = t_q[0];
		src_val[cis2d_pkg::S_T1]   = t_q[1];
		src_val[cis2d_pkg::S_T2]   = t_q[2];
		src_val[cis2d_pkg::S_T3]   = t_q[3];
		src_val[cis2d_pkg::S_JAN]  = jan_q;
		src_val[cis2d_pkg::S_JBN]  = jbn_q;
		src_val[cis2d_pkg::S_JAT]  = jat_q;
		src_val[cis2d_pkg::S_JBT]  = jbt_q;
	end

	assign opa = src_val[u.a];
	assign opb = src_val[u.b];

	// The multiply shifts by 14 for the Q2.14 coefficient products.
	assign prod    = opa * opb;
	assign prod_sh = (u.op == cis2d_pkg::OP_MULQ) ? (prod >>> cis2d_pkg::Q14)
		: (prod >>> cis2d_pkg::FRAC_BITS);

	always_comb begin
		case (u.op)
			cis2d_pkg::OP_MUL, cis2d_pkg::OP_MULQ: res = cis2d_pkg::sat64(prod_sh);
			cis2d_pkg::OP_ADD: res = cis2d_pkg::sat33({opa[31], opa} + {opb[31], opb});
			cis2d_pkg::OP_SUB: res = cis2d_pkg::sat33({opa[31], opa} - {opb[31], opb});
			cis2d_pkg::OP_NEG: res = cis2d_pkg::sat33(33'sd0 - {opa[31], opa});
			cis2d_pkg::OP_MIN: res = (opa < opb) ? opa : opb;
			cis2d_pkg::OP_MAX: res = (opa > opb) ? opa : opb;
			default:           res = '0;
		endcase
	end

	cis2d_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.den    (opa),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign wen   = cmd.exec || div_done;
	assign wdata = div_done ? div_quo : res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_a_q    <= '0;
			arm_b_q    <= '0;
			normal_q   <= '0;
			tangent_q  <= '0;
			depth_q    <= '0;
			inv_mass_q <= '0;
			inv_iner_q <= '0;
			coef_q     <= '0;
			nt_q       <= '0;
			ft_q       <= '0;
			mn_q       <= '0;
			mt_q       <= '0;
			restart_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cis2d_pkg::CFG_ARM_A:    arm_a_q    <= cfg_data;
					cis2d_pkg::CFG_ARM_B:    arm_b_q    <= cfg_data;
					cis2d_pkg::CFG_NORMAL:   normal_q   <= cfg_data;
					cis2d_pkg::CFG_TANGENT:  tangent_q  <= cfg_data;
					cis2d_pkg::CFG_DEPTH:    depth_q    <= cfg_data[31:0];
					cis2d_pkg::CFG_INV_MASS: inv_mass_q <= cfg_data;
					cis2d_pkg::CFG_INV_INER: inv_iner_q <= cfg_data;
					cis2d_pkg::CFG_COEF:     coef_q     <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				restart_q <= restart;
			end
			if (wen) begin
				case (u.d)
					cis2d_pkg::D_NT: nt_q <= wdata;
					cis2d_pkg::D_FT: ft_q <= wdata;
					cis2d_pkg::D_MN: mn_q <= wdata;
					cis2d_pkg::D_MT: mt_q <= wdata;
					default: ;
				endcase
			end
		end
	end

	// Working registers carry no reset; each item writes them before use.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q[0] <= vel_a_x;
			v_q[1] <= vel_a_y;
			v_q[2] <= spin_a;
			v_q[3] <= vel_b_x;
			v_q[4] <= vel_b_y;
			v_q[5] <= spin_b;
		end
		if (wen) begin
			case (u.d)
				cis2d_pkg::D_O0:  o_q[0] <= wdata;
				cis2d_pkg::D_O1:  o_q[1] <= wdata;
				cis2d_pkg::D_O2:  o_q[2] <= wdata;
				cis2d_pkg::D_O3:  o_q[3] <= wdata;
				cis2d_pkg::D_O4:  o_q[4] <= wdata;
				cis2d_pkg::D_O5:  o_q[5] <= wdata;
				cis2d_pkg::D_T0:  t_q[0] <= wdata;
				cis2d_pkg::D_T1:  t_q[1] <= wdata;
				cis2d_pkg::D_T2:  t_q[2] <= wdata;
				cis2d_pkg::D_T3:  t_q[3] <= wdata;
				cis2d_pkg::D_JAN: jan_q  <= wdata;
				cis2d_pkg::D_JBN: jbn_q  <= wdata;
				cis2d_pkg::D_JAT: jat_q  <= wdata;
				cis2d_pkg::D_JBT: jbt_q  <= wdata;
				default: ;
			endcase
		end
		if (cmd.publish) begin
			for (int i = 0; i < 6; i++) out_q[i] <= o_q[i];
			out_nt_q <= nt_q[30:0];
			out_ft_q <= ft_q;
		end
	end

	assign sts.restart  = restart_q;
	assign sts.div_done = div_done;

	assign new_vel_a_x            = out_q[0];
	assign new_vel_a_y            = out_q[1];
	assign new_spin_a             = out_q[2];
	assign new_vel_b_x            = out_q[3];
	assign new_vel_b_y            = out_q[4];
	assign new_spin_b             = out_q[5];
	assign normal_impulse_total   = out_nt_q;
	assign friction_impulse_total = out_ft_q;

endmodule

/* sv/cis2d_ctrl.sv */
// ----------------------------------------------------------------------------
// cis2d_ctrl: solver sequencer
// Walks the step table for each accepted word, waits on the reciprocal unit
// and hands the finished word to the output register.
// ----------------------------------------------------------------------------
module cis2d_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  cis2d_pkg::sts_t sts,
	output cis2d_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DIVW, S_FIN} state_t;

	state_t           state_q;
	cis2d_pkg::step_t step_q;
	cis2d_pkg::uop_t  cur_uop;
	logic             out_valid_q;
	logic             is_recip;
	logic             out_free;

	assign cur_uop  = cis2d_pkg::uop_rom(step_q);
	assign is_recip = (cur_uop.op == cis2d_pkg::OP_RECIP);
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !cmd.publish) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						step_q  <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (is_recip) begin
						state_q <= S_DIVW;
					end else if (step_q == cis2d_pkg::STEP_SPLIT && !sts.restart) begin
						step_q <= cis2d_pkg::STEP_NORMAL;
					end else if (step_q == cis2d_pkg::STEP_LAST) begin
						state_q <= S_FIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DIVW: begin
					if (sts.div_done) begin
						step_q  <= step_q + 1'b1;
						state_q <= S_RUN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign cmd.load      = in_valid && in_ready;
	assign cmd.exec      = (state_q == S_RUN) && !is_recip;
	assign cmd.div_start = (state_q == S_RUN) && is_recip;
	assign cmd.publish   = (state_q == S_FIN) && out_free;
	assign cmd.step      = step_q;

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_RUN && step_q == '0)
		else $error("accepted word did not start the sequence");
	a_div_waits: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == S_DIVW)
		else $error("reciprocal finished outside its wait state");
	a_publish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid_q)
		else $error("published word not shown on the output");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> step_q <= cis2d_pkg::STEP_LAST)
		else $error("step counter ran past the last step");

endmodule

/* sv/contact_impulse_solver_2d_unit.sv */
// ----------------------------------------------------------------------------
// contact_impulse_solver_2d_unit: 2D contact impulse solver, top level
// One sequential-impulse iteration per word for a single contact between two
// bodies: clamped normal impulse with restitution and depth bias, then
// friction clamped by the normal total, both on the incoming velocities.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Payload
//   in_ch     sink        restart, vel_a_x/y, spin_a, vel_b_x/y, spin_b
//   out_ch    source      new velocities and spins, both impulse totals
//   cfg_*     write only  cfg_index selects one of eight registers, cfg_data
//
// A word without restart runs 115 steps of the step table, each through the
// single multiplier or the saturating add and compare, and then loads the
// output register; the next word is accepted only after that. A restart word
// adds 18 steps, two of them reciprocals that hold the sequence on the
// bit-serial divider, which produces 2*FRAC_BITS+1 quotient bits.
// Reset clears the configuration, the totals and the effective masses at once.
// A new word is accepted while the previous result still waits on out_ch; the
// sequence then holds at its end until the output register is free.
//
module contact_impulse_solver_2d_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [3:0]       cfg_index,
	input  logic [63:0]      cfg_data,
	cis2d_in_if.sink         in_ch,
	cis2d_out_if.source      out_ch
);

	// Commands run from the sequencer into the datapath, status runs back.
	cis2d_pkg::cmd_t cmd;
	cis2d_pkg::sts_t sts;

	cis2d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the registers, the arithmetic and the result word.
	cis2d_dp u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg_we                 (cfg_we),
		.cfg_index              (cfg_index),
		.cfg_data               (cfg_data),
		.restart                (in_ch.restart),
		.vel_a_x                (in_ch.vel_a_x),
		.vel_a_y                (in_ch.vel_a_y),
		.spin_a                 (in_ch.spin_a),
		.vel_b_x                (in_ch.vel_b_x),
		.vel_b_y                (in_ch.vel_b_y),
		.spin_b                 (in_ch.spin_b),
		.cmd                    (cmd),
		.sts                    (sts),
		.new_vel_a_x            (out_ch.new_vel_a_x),
		.new_vel_a_y            (out_ch.new_vel_a_y),
		.new_spin_a             (out_ch.new_spin_a),
		.new_vel_b_x            (out_ch.new_vel_b_x),
		.new_vel_b_y            (out_ch.new_vel_b_y),
		.new_spin_b             (out_ch.new_spin_b),
		.normal_impulse_total   (out_ch.normal_impulse_total),
		.friction_impulse_total (out_ch.friction_impulse_total)
	);

endmodule
